>>> design/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants for the channel pending request counter:
// operation and status codes, field widths and the update result bundle.
// ----------------------------------------------------------------------------
package cpr_pkg;

   // channel storage and configuration
   localparam int MAX_CHANNELS = 16;
   localparam int CHANNELS     = 16;
   localparam int IDX_W        = $clog2(MAX_CHANNELS);

   // field widths
   localparam int FUNC_W   = 2;
   localparam int CHAN_W   = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 8;
   localparam int TOTAL_W  = 12;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd2;

   // saturation limit of one channel count
   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

   typedef logic [MAX_CHANNELS-1:0] mask_type;
   typedef logic [TOTAL_W-1:0]      total_type;
   typedef logic [COUNT_W-1:0]      count_type;

   // outcome of one transaction, from the update logic to the top level
   typedef struct packed {
      logic                wr_en;
      logic [IDX_W-1:0]    idx;
      logic [STATUS_W-1:0] status;
      count_type           count;
      mask_type            mask;
      total_type           total;
   } upd_type;

endpackage

>>> design/cpr_update.sv
// ----------------------------------------------------------------------------
// cpr_update
// Next-state logic for one transaction: decides the status and computes the
// new channel count, busy mask and running total.
// ----------------------------------------------------------------------------
module cpr_update (
   input  logic [cpr_pkg::FUNC_W-1:0] func,
   input  logic [cpr_pkg::CHAN_W-1:0] channel,
   input  cpr_pkg::count_type         cur_count,
   input  cpr_pkg::mask_type          cur_mask,
   input  cpr_pkg::total_type         cur_total,
   output cpr_pkg::upd_type           upd
);

   logic                      in_range;
   logic [cpr_pkg::IDX_W-1:0] idx;
   cpr_pkg::mask_type         bit_sel;

   // channel decode
   assign in_range = (channel < cpr_pkg::CHAN_W'(cpr_pkg::CHANNELS));
   assign idx      = channel[cpr_pkg::IDX_W-1:0];
   assign bit_sel  = cpr_pkg::mask_type'(1) << idx;

   // operation
   always_comb begin
      upd        = '0;
      upd.idx    = idx;
      upd.status = cpr_pkg::ST_OK;
      upd.count  = cur_count;
      upd.mask   = cur_mask;
      upd.total  = cur_total;
      if (!in_range) begin
         upd.status = cpr_pkg::ST_INVALID;
         upd.count  = '0;
      end else begin
         case (func)
            cpr_pkg::FUNC_ADD: begin
               if (cur_count == cpr_pkg::COUNT_MAX) begin
                  upd.status = cpr_pkg::ST_TOO_MANY;
               end else begin
                  upd.wr_en = 1'b1;
                  upd.count = cur_count + 1'b1;
                  upd.mask  = cur_mask | bit_sel;
                  upd.total = cur_total + 1'b1;
               end
            end
            cpr_pkg::FUNC_REMOVE: begin
               if (cur_count == '0) begin
                  upd.status = cpr_pkg::ST_INVALID;
               end else begin
                  upd.wr_en = 1'b1;
                  upd.count = cur_count - 1'b1;
                  if (cur_count == cpr_pkg::count_type'(1)) begin
                     upd.mask = cur_mask & ~bit_sel;
                  end
                  upd.total = cur_total - 1'b1;
               end
            end
            cpr_pkg::FUNC_CLEAR: begin
               upd.wr_en = 1'b1;
               upd.count = '0;
               upd.mask  = cur_mask & ~bit_sel;
               upd.total = cur_total - cpr_pkg::TOTAL_W'(cur_count);
            end
            default: begin
               upd.status = cpr_pkg::ST_INVALID;
            end
         endcase
      end
   end

endmodule

>>> design/channel_pending_request_counter.sv
// Pipeline: a transaction accepted into the request register has its result
// loaded into the response register and shown on the response ports from there.
// Throughput: one transaction per cycle while the response side does not stall;
// the read-modify-write of the counter file, busy mask and total is combinational
// logic between the request register and the response register.
// Reset: synchronous; clears all channel counts, the mask, the total and
// both pipeline valid flags.
// ----------------------------------------------------------------------------
// channel_pending_request_counter
// Per-channel pending request counters with a busy mask and running total.
// ----------------------------------------------------------------------------
module channel_pending_request_counter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [cpr_pkg::FUNC_W-1:0]     req_func,
   input  logic [cpr_pkg::CHAN_W-1:0]     req_channel,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [cpr_pkg::STATUS_W-1:0]   rsp_status,
   output cpr_pkg::mask_type              rsp_pending_mask,
   output cpr_pkg::total_type             rsp_pending_total,
   output cpr_pkg::count_type             rsp_channel_count
);

   logic                         req_vld_ff;
   logic                         req_vld_in;
   logic [cpr_pkg::FUNC_W-1:0]   req_func_ff;
   logic [cpr_pkg::CHAN_W-1:0]   req_chan_ff;
   cpr_pkg::count_type           count_ff [cpr_pkg::MAX_CHANNELS];
   cpr_pkg::mask_type            mask_ff;
   cpr_pkg::total_type           total_ff;
   logic                         rsp_vld_ff;
   logic                         rsp_vld_in;
   logic [cpr_pkg::STATUS_W-1:0] rsp_status_ff;
   cpr_pkg::mask_type            rsp_mask_ff;
   cpr_pkg::total_type           rsp_total_ff;
   cpr_pkg::count_type           rsp_count_ff;
   logic                         rsp_load;
   logic                         req_load;
   cpr_pkg::upd_type             upd;

   // pipeline flow control
   assign rsp_load  = req_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = req_vld_ff && !rsp_load;
   assign req_load  = req_valid && !req_stall;

   assign req_vld_in = req_load || (req_vld_ff && !rsp_load);
   assign rsp_vld_in = rsp_load || (rsp_vld_ff && rsp_stall);

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
      end
      if (req_load) begin
         req_func_ff <= req_func;
         req_chan_ff <= req_channel;
      end
   end

   // update logic
   cpr_update u_update (
      .func      (req_func_ff),
      .channel   (req_chan_ff),
      .cur_count (count_ff[req_chan_ff[cpr_pkg::IDX_W-1:0]]),
      .cur_mask  (mask_ff),
      .cur_total (total_ff),
      .upd       (upd)
   );

   // counter file, mask and total
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cpr_pkg::MAX_CHANNELS; i++) begin
            count_ff[i] <= '0;
         end
         mask_ff  <= '0;
         total_ff <= '0;
      end else if (rsp_load) begin
         if (upd.wr_en) begin
            count_ff[upd.idx] <= upd.count;
         end
         mask_ff  <= upd.mask;
         total_ff <= upd.total;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      if (rsp_load) begin
         rsp_status_ff <= upd.status;
         rsp_mask_ff   <= upd.mask;
         rsp_total_ff  <= upd.total;
         rsp_count_ff  <= upd.count;
      end
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_pending_mask  = rsp_mask_ff;
   assign rsp_pending_total = rsp_total_ff;
   assign rsp_channel_count = rsp_count_ff;

endmodule

>>> design/cpr_checker.sv
// ----------------------------------------------------------------------------
// cpr_checker
// Port-level checks for the channel pending request counter.
// ----------------------------------------------------------------------------
module cpr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [cpr_pkg::STATUS_W-1:0] rsp_status,
   input cpr_pkg::mask_type            rsp_pending_mask,
   input cpr_pkg::total_type           rsp_pending_total,
   input cpr_pkg::count_type           rsp_channel_count
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_pending_mask) && $stable(rsp_pending_total)
         && $stable(rsp_channel_count))
      else $error("stalled response changed");

   // no response and no input stall right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response valid or input stalled after reset");

   // empty mask exactly when total is zero
   a_mask_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_pending_mask == '0) == (rsp_pending_total == '0)))
      else $error("mask and total disagree");

   // saturation reports a full counter
   a_too_many: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == cpr_pkg::ST_TOO_MANY)
         |-> (rsp_channel_count == cpr_pkg::COUNT_MAX))
      else $error("too-many status without full count");

   // a nonzero ok count shows in the mask
   a_count_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == cpr_pkg::ST_OK) && (rsp_channel_count != '0)
         |-> (rsp_pending_mask != '0))
      else $error("pending count with empty mask");

endmodule

bind channel_pending_request_counter cpr_checker u_cpr_checker (.*);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the channel pending request counter against its own running model.
// Every accepted transaction updates the per-channel counts, busy mask and
// total, and the response is checked field by field. The run covers a short
// directed set and a count saturation with a long response hold-off that
// backs up the input. Random add, remove, clear and invalid traffic follows, with
// random gaps on both sides.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cpr_pkg::*;

   // the package names no code for the fourth function value
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   localparam int CLOCK_HALF      = 5;
   localparam int RESET_CYCLES    = 9;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int DRAIN_CYCLES    = 8;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int MAX_REPORTS     = 10;

   // expected response of one transaction
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      mask_type            mask;
      total_type           total;
      count_type           count;
   } response_type;

   // running model of the counters and queue of expected responses
   class pending_scoreboard;
      count_type    chan_count[MAX_CHANNELS];
      mask_type     busy;
      total_type    total;
      response_type expected_responses[$];
      int           mismatches;

      function new();
         foreach (chan_count[i]) chan_count[i] = '0;
         busy       = '0;
         total      = '0;
         mismatches = 0;
      endfunction

      function void note_request(logic [FUNC_W-1:0] func, logic [CHAN_W-1:0] channel);
         response_type     rsp;
         logic [IDX_W-1:0] idx;
         count_type        cnt;
         rsp.status = ST_OK;
         cnt        = '0;
         if (channel >= CHANNELS) begin
            rsp.status = ST_INVALID;
         end else begin
            idx = channel[IDX_W-1:0];
            cnt = chan_count[idx];
            case (func)
               FUNC_ADD: begin
                  // saturate at the top count
                  if (cnt == COUNT_MAX) begin
                     rsp.status = ST_TOO_MANY;
                  end else begin
                     cnt        = cnt + 1'b1;
                     busy[idx]  = 1'b1;
                     total      = total + 1'b1;
                  end
               end
               FUNC_REMOVE: begin
                  // never go below zero
                  if (cnt == '0) begin
                     rsp.status = ST_INVALID;
                  end else begin
                     cnt   = cnt - 1'b1;
                     total = total - 1'b1;
                     if (cnt == '0) busy[idx] = 1'b0;
                  end
               end
               FUNC_CLEAR: begin
                  total     = total - total_type'(cnt);
                  cnt       = '0;
                  busy[idx] = 1'b0;
               end
               default: begin
                  rsp.status = ST_INVALID;
               end
            endcase
            chan_count[idx] = cnt;
         end
         rsp.mask  = busy;
         rsp.total = total;
         rsp.count = cnt;
         expected_responses.push_back(rsp);
      endfunction

      function void check_response(response_type actual);
         response_type exp_rsp;
         if (expected_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: status %0d mask %h total %0d count %0d",
                        actual.status, actual.mask, actual.total, actual.count);
         end else begin
            exp_rsp = expected_responses.pop_front();
            if (actual.status !== exp_rsp.status || actual.mask !== exp_rsp.mask ||
                actual.total !== exp_rsp.total || actual.count !== exp_rsp.count) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch: expected status %0d mask %h total %0d count %0d, %s",
                           exp_rsp.status, exp_rsp.mask, exp_rsp.total, exp_rsp.count,
                           $sformatf("got status %0d mask %h total %0d count %0d",
                                     actual.status, actual.mask, actual.total,
                                     actual.count));
            end
         end
      endfunction

      function int outstanding();
         return expected_responses.size();
      endfunction
   endclass

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func    = FUNC_ADD;
   logic [CHAN_W-1:0]   req_channel = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   mask_type            rsp_pending_mask;
   total_type           rsp_pending_total;
   count_type           rsp_channel_count;

   pending_scoreboard sb = new();

   bit idle_enable       = 1'b1;
   int hold_off_requests = 0;
   int hold_off_served   = 0;
   int stall_left        = 0;
   int cycle_count       = 0;

   channel_pending_request_counter u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_channel       (req_channel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_pending_mask  (rsp_pending_mask),
      .rsp_pending_total (rsp_pending_total),
      .rsp_channel_count (rsp_channel_count)
   );

   always #CLOCK_HALF clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_enable || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // offer one transaction and wait until it is taken
   task automatic send_request(input logic [FUNC_W-1:0] func, input logic [CHAN_W-1:0] channel);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_channel <= channel;
      do @(posedge clock); while (req_stall);
      sb.note_request(func, channel);
   endtask

   // random transaction, mostly on valid channels
   task automatic send_random_request();
      int                r;
      logic [FUNC_W-1:0] func;
      logic [CHAN_W-1:0] channel;
      r       = $urandom_range(0, 99);
      channel = CHAN_W'($urandom_range(0, CHANNELS - 1));
      if (r < 8) begin
         channel = CHAN_W'($urandom_range(CHANNELS, 255));
         func    = FUNC_W'($urandom_range(0, 3));
      end else if (r < 12) begin
         func = FUNC_UNUSED;
      end else if (r < 62) begin
         func = FUNC_ADD;
      end else if (r < 92) begin
         func = FUNC_REMOVE;
      end else begin
         func = FUNC_CLEAR;
      end
      send_request(func, channel);
   endtask

   // random traffic with occasional add bursts on one channel
   task automatic run_random(input int items);
      int                sent;
      int                burst;
      logic [CHAN_W-1:0] channel;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 99) < 5) begin
            burst   = $urandom_range(5, 30);
            channel = CHAN_W'($urandom_range(0, CHANNELS - 1));
            repeat (burst) send_request(FUNC_ADD, channel);
            sent += burst;
         end else begin
            send_random_request();
            sent++;
         end
      end
   endtask

   // response side: check accepted transactions, then choose the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response('{rsp_status, rsp_pending_mask, rsp_pending_total,
                             rsp_channel_count});
      if (hold_off_served != hold_off_requests) begin
         hold_off_served = hold_off_requests;
         stall_left      = HOLD_OFF_CYCLES;
      end else if (stall_left == 0) begin
         stall_left = pick_gap();
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: basic operations, empty cases, invalid channels, unused code
      send_request(FUNC_ADD, 8'd0);
      send_request(FUNC_ADD, 8'd0);
      send_request(FUNC_REMOVE, 8'd0);
      send_request(FUNC_REMOVE, 8'd0);
      send_request(FUNC_REMOVE, 8'd0);
      send_request(FUNC_CLEAR, 8'd0);
      send_request(FUNC_ADD, 8'd15);
      send_request(FUNC_ADD, 8'd15);
      send_request(FUNC_ADD, 8'd7);
      send_request(FUNC_CLEAR, 8'd15);
      send_request(FUNC_UNUSED, 8'd7);
      send_request(FUNC_UNUSED, 8'd0);
      send_request(FUNC_UNUSED, 8'd200);
      send_request(FUNC_ADD, 8'd16);
      send_request(FUNC_REMOVE, 8'd255);
      send_request(FUNC_CLEAR, 8'd128);
      send_request(FUNC_ADD, 8'd85);
      send_request(FUNC_ADD, 8'd170);
      send_request(FUNC_ADD, 8'd8);
      send_request(FUNC_CLEAR, 8'd7);
      send_request(FUNC_REMOVE, 8'd8);

      // saturate one channel back to back while the response side holds off
      idle_enable = 1'b0;
      hold_off_requests++;
      repeat (257) send_request(FUNC_ADD, 8'd15);
      send_request(FUNC_REMOVE, 8'd15);
      send_request(FUNC_ADD, 8'd15);
      send_request(FUNC_ADD, 8'd15);
      idle_enable = 1'b1;

      // random traffic, with a stretch of no idling in the middle
      run_random(150);
      idle_enable = 1'b0;
      run_random(80);
      idle_enable = 1'b1;
      run_random(40);
      send_request(FUNC_CLEAR, 8'd15);
      req_valid <= 1'b0;

      // drain, then allow for any stray responses
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
